// File: hw/rtl/acmm_pkg.sv
// ---------------------------------------------------------------------------
// acmm_pkg: channel matrix mixer shared definitions
// Sizes, field types, codes and the control structs that pass between
// the sequencer, the multiplier lanes and the merge tree.
// ---------------------------------------------------------------------------
`default_nettype none

package acmm_pkg;

	localparam int MAX_CHANNELS   = 8;
	localparam int LANES          = 8;
	localparam int COEF_FRAC_BITS = 16;
	localparam int CHAN_CAP       = (MAX_CHANNELS < LANES) ? MAX_CHANNELS : LANES;

	localparam int SAMPLE_W = 32;
	localparam int COEF_W   = 18;
	localparam int SLOT_W   = 6;
	localparam int CNT_W    = 4;
	localparam int CH_W     = $clog2(LANES);
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int ACC_W    = PROD_W + $clog2(LANES);
	localparam int SHIFT_W  = ACC_W - COEF_FRAC_BITS;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic        [SLOT_W-1:0]   slot_t;
	typedef logic        [CNT_W-1:0]    count_t;
	typedef logic        [CH_W-1:0]     chan_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	localparam sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;
	localparam sample_t SAMPLE_MIN = 32'sh8000_0000;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_MIX  = 1'b1
	} op_t;

	typedef enum logic {
		CFG_IN_CHANNELS  = 1'b0,
		CFG_OUT_CHANNELS = 1'b1
	} cfg_idx_t;

	// coefficient write into one lane bank
	typedef struct packed {
		logic  en;
		chan_t addr;
		coef_t data;
	} coef_wr_t;

	// tag that travels with one output channel through the lanes and merge
	typedef struct packed {
		logic  valid;
		chan_t chan;
		logic  last;
	} tag_t;

	// one finished output channel
	typedef struct packed {
		logic    valid;
		chan_t   chan;
		logic    last;
		sample_t value;
		logic    clip;
	} mix_res_t;

	function automatic count_t limit_count(count_t n);
		if (n > count_t'(CHAN_CAP)) begin
			return count_t'(CHAN_CAP);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/acmm_if.sv
// ---------------------------------------------------------------------------
// acmm_if: channel matrix mixer stream and configuration interfaces
// Input item channel, result item channel and register write channel,
// each a valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface acmm_in_if;
	import acmm_pkg::*;
	logic    valid;
	logic    ready;
	op_t     operation;
	sample_t sample_0;
	sample_t sample_1;
	sample_t sample_2;
	sample_t sample_3;
	sample_t sample_4;
	sample_t sample_5;
	sample_t sample_6;
	sample_t sample_7;
	slot_t   coef_index;
	coef_t   coef_value;
	logic    end_of_buffer;

	modport source (
		output valid, operation, sample_0, sample_1, sample_2, sample_3,
		       sample_4, sample_5, sample_6, sample_7, coef_index, coef_value,
		       end_of_buffer,
		input  ready
	);
	modport sink (
		input  valid, operation, sample_0, sample_1, sample_2, sample_3,
		       sample_4, sample_5, sample_6, sample_7, coef_index, coef_value,
		       end_of_buffer,
		output ready
	);
endinterface

interface acmm_out_if;
	import acmm_pkg::*;
	logic                valid;
	logic                ready;
	sample_t             out_sample_0;
	sample_t             out_sample_1;
	sample_t             out_sample_2;
	sample_t             out_sample_3;
	sample_t             out_sample_4;
	sample_t             out_sample_5;
	sample_t             out_sample_6;
	sample_t             out_sample_7;
	logic [LANES-1:0]    clipped_mask;
	logic                last_frame;

	modport source (
		output valid, out_sample_0, out_sample_1, out_sample_2, out_sample_3,
		       out_sample_4, out_sample_5, out_sample_6, out_sample_7,
		       clipped_mask, last_frame,
		input  ready
	);
	modport sink (
		input  valid, out_sample_0, out_sample_1, out_sample_2, out_sample_3,
		       out_sample_4, out_sample_5, out_sample_6, out_sample_7,
		       clipped_mask, last_frame,
		output ready
	);
endinterface

interface acmm_cfg_if;
	import acmm_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	count_t   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/acmm_lane.sv
// ---------------------------------------------------------------------------
// acmm_lane: one input channel multiplier lane
// Holds the coefficient row of one input channel (one entry per output
// channel, zero until written), reads the entry of the output channel in
// flight and multiplies it by the lane's sample.
// ---------------------------------------------------------------------------
`default_nettype none

module acmm_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  acmm_pkg::coef_wr_t wr,
	input  acmm_pkg::chan_t    rd_addr,
	input  acmm_pkg::sample_t  sample,
	output acmm_pkg::prod_t    prod_s2
);
	import acmm_pkg::*;

	coef_t            mem_q [LANES];
	logic [LANES-1:0] valid_q;
	coef_t            coef_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		// an entry never written reads as the reset value, zero
		coef_s1 <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
		prod_s2 <= sample * coef_s1;
	end

endmodule

`default_nettype wire

// File: hw/rtl/acmm_merge.sv
// ---------------------------------------------------------------------------
// acmm_merge: lane merge, scaling and saturation
// Registered adder tree over the lane products, then an arithmetic shift
// by the fraction bits and saturation to the signed 32-bit range.
// ---------------------------------------------------------------------------
`default_nettype none

module acmm_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  acmm_pkg::prod_t    prod_s2 [acmm_pkg::LANES],
	input  acmm_pkg::tag_t     tag_s2,
	output acmm_pkg::mix_res_t res
);
	import acmm_pkg::*;

	localparam int L1 = LANES / 2;
	localparam int L2 = LANES / 4;
	localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'(SAMPLE_MAX);
	localparam logic signed [SHIFT_W-1:0] SAT_LO = SHIFT_W'(SAMPLE_MIN);

	acc_t                      sum_s3 [L1];
	acc_t                      sum_s4 [L2];
	acc_t                      acc_s5;
	tag_t                      tag_s3;
	tag_t                      tag_s4;
	tag_t                      tag_s5;
	tag_t                      tag_s6;
	sample_t                   value_s6;
	logic                      clip_s6;
	acc_t                      shifted_full;
	logic signed [SHIFT_W-1:0] shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
		end else begin
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
		end
	end

	// floor division by the coefficient scale
	always_comb begin
		shifted_full = acc_s5 >>> COEF_FRAC_BITS;
		shifted      = $signed(shifted_full[SHIFT_W-1:0]);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < L1; k++) begin
			sum_s3[k] <= acc_t'(prod_s2[2*k]) + acc_t'(prod_s2[2*k+1]);
		end
		for (int k = 0; k < L2; k++) begin
			sum_s4[k] <= sum_s3[2*k] + sum_s3[2*k+1];
		end
		acc_s5 <= sum_s4[0] + sum_s4[1];

		if (shifted > SAT_HI) begin
			value_s6 <= SAMPLE_MAX;
			clip_s6  <= 1'b1;
		end else if (shifted < SAT_LO) begin
			value_s6 <= SAMPLE_MIN;
			clip_s6  <= 1'b1;
		end else begin
			value_s6 <= $signed(shifted[SAMPLE_W-1:0]);
			clip_s6  <= 1'b0;
		end
	end

	assign res = '{valid: tag_s6.valid, chan: tag_s6.chan, last: tag_s6.last,
	               value: value_s6, clip: clip_s6};

endmodule

`default_nettype wire

// File: hw/rtl/audio_channel_matrix_mixer.sv
// ---------------------------------------------------------------------------
// audio_channel_matrix_mixer: coefficient matrix channel mixer
// in_ch carries items: a load item writes one Q1.16 coefficient at slot
// input*8+output and gives no result; a mix item gives one result item on
// out_ch with every output channel the saturated, scaled sum of sample
// times coefficient, a clip flag per output and the end-of-buffer mark.
// cfg sets in_channels (index 0) and out_channels (index 1); write it only
// while the block is idle. Counts above eight act as eight.
// After a mix item, the next item is taken in the cycle the result is
// shown. The output-channel sequencer steps one output channel per cycle
// into eight multiplier lanes, one per input channel, followed by a
// four-stage merge tree with scaling and saturation.
// Reset clears the coefficient matrix to zero (valid bits per entry) and
// sets both counts to two. A stalled receiver holds the result register;
// loads and a further mix are still taken, and a finished mix waits in its
// working buffer until the result register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module audio_channel_matrix_mixer (
	input logic       clk,
	input logic       arst_n,
	acmm_in_if.sink   in_ch,
	acmm_out_if.source out_ch,
	acmm_cfg_if.sink  cfg
);
	import acmm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_HAND
	} state_t;

	state_t           state_q;
	count_t           in_channels_q;
	count_t           out_channels_q;
	count_t           no_q;
	chan_t            cnt_q;
	logic             out_valid_q;
	tag_t             tag_s0;
	tag_t             tag_s1;
	tag_t             tag_s2;

	sample_t          in_samples [LANES];
	sample_t          sample_q [LANES];
	sample_t          res_sample_q [LANES];
	logic [LANES-1:0] res_clip_q;
	logic             last_q;
	sample_t          out_sample_q [LANES];
	logic [LANES-1:0] out_clip_q;
	logic             out_last_q;

	coef_wr_t         wr [LANES];
	prod_t            prod [LANES];
	mix_res_t         res;

	logic             in_acc;
	logic             mix_acc;
	logic             load_acc;
	logic             hand_go;
	logic             cnt_last;
	count_t           ni;
	count_t           no;

	assign in_samples[0] = in_ch.sample_0;
	assign in_samples[1] = in_ch.sample_1;
	assign in_samples[2] = in_ch.sample_2;
	assign in_samples[3] = in_ch.sample_3;
	assign in_samples[4] = in_ch.sample_4;
	assign in_samples[5] = in_ch.sample_5;
	assign in_samples[6] = in_ch.sample_6;
	assign in_samples[7] = in_ch.sample_7;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign mix_acc  = in_acc && (in_ch.operation == OP_MIX);
	assign load_acc = in_acc && (in_ch.operation == OP_LOAD);
	assign ni       = limit_count(in_channels_q);
	assign no       = limit_count(out_channels_q);
	assign hand_go  = (state_q == ST_HAND) && (!out_valid_q || out_ch.ready);
	assign cnt_last = (count_t'(cnt_q) == no_q - count_t'(1));

	always_comb begin
		tag_s0 = '{valid: (state_q == ST_RUN), chan: cnt_q, last: cnt_last};
	end

	// slot splits into input channel (lane) and output channel (entry)
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			wr[i].en   = load_acc && (in_ch.coef_index[SLOT_W-1:CH_W] == (SLOT_W-CH_W)'(i));
			wr[i].addr = in_ch.coef_index[CH_W-1:0];
			wr[i].data = in_ch.coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			in_channels_q  <= count_t'(2);
			out_channels_q <= count_t'(2);
			no_q           <= '0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
			tag_s1         <= '0;
			tag_s2         <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_IN_CHANNELS:  in_channels_q  <= cfg.data;
					CFG_OUT_CHANNELS: out_channels_q <= cfg.data;
				endcase
			end
			tag_s1 <= tag_s0;
			tag_s2 <= tag_s1;
			// a new result replaces the one taken in the same cycle
			if (hand_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (mix_acc) begin
						no_q    <= no;
						cnt_q   <= '0;
						state_q <= (no == '0) ? ST_HAND : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + chan_t'(1);
					if (cnt_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (res.valid && res.last) begin
						state_q <= ST_HAND;
					end
				end
				ST_HAND: begin
					if (hand_go) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mix_acc) begin
			for (int i = 0; i < LANES; i++) begin
				// unused input channels contribute nothing
				sample_q[i]     <= (count_t'(i) < ni) ? in_samples[i] : '0;
				res_sample_q[i] <= '0;
			end
			res_clip_q <= '0;
			last_q     <= in_ch.end_of_buffer;
		end
		if (res.valid) begin
			res_sample_q[res.chan] <= res.value;
			res_clip_q[res.chan]   <= res.clip;
		end
		if (hand_go) begin
			out_sample_q <= res_sample_q;
			out_clip_q   <= res_clip_q;
			out_last_q   <= last_q;
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		acmm_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr[g]),
			.rd_addr (cnt_q),
			.sample  (sample_q[g]),
			.prod_s2 (prod[g])
		);
	end

	acmm_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.prod_s2 (prod),
		.tag_s2  (tag_s2),
		.res     (res)
	);

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_sample_0 = out_sample_q[0];
	assign out_ch.out_sample_1 = out_sample_q[1];
	assign out_ch.out_sample_2 = out_sample_q[2];
	assign out_ch.out_sample_3 = out_sample_q[3];
	assign out_ch.out_sample_4 = out_sample_q[4];
	assign out_ch.out_sample_5 = out_sample_q[5];
	assign out_ch.out_sample_6 = out_sample_q[6];
	assign out_ch.out_sample_7 = out_sample_q[7];
	assign out_ch.clipped_mask = out_clip_q;
	assign out_ch.last_frame   = out_last_q;

	a_res_in_mix: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == ST_RUN || state_q == ST_WAIT))
		else $error("merge result outside a mix");

	a_res_chan: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (count_t'(res.chan) < no_q))
		else $error("merge result for an unused output channel");

	a_clip_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_clip_q >> no) == '0))
		else $error("clip flag on an unused output channel");

	a_hand: assert property (@(posedge clk) disable iff (!arst_n)
		hand_go |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished mix not moved to the result register");

endmodule

`default_nettype wire
